>>> rtl/idalloc_pkg.sv
`default_nettype none
package idalloc_pkg;

    localparam int ID_W  = 6;
    localparam int CNT_W = 7;

    localparam logic [2:0] OP_ALLOC = 3'd0;
    localparam logic [2:0] OP_FREE  = 3'd1;
    localparam logic [2:0] OP_MARK  = 3'd2;
    localparam logic [2:0] OP_SWEEP = 3'd3;
    localparam logic [2:0] OP_LIST  = 3'd4;

    localparam logic [2:0] KIND_ALLOC  = 3'd0;
    localparam logic [2:0] KIND_KILLED = 3'd1;
    localparam logic [2:0] KIND_LISTED = 3'd2;
    localparam logic [2:0] KIND_NONE   = 3'd3;
    localparam logic [2:0] KIND_ERROR  = 3'd4;

    localparam logic [1:0] ERR_NONE  = 2'd0;
    localparam logic [1:0] ERR_FULL  = 2'd1;
    localparam logic [1:0] ERR_RANGE = 2'd2;
    localparam logic [1:0] ERR_DEAD  = 2'd3;

    // Datapath actions issued by the controller, one per cycle.
    typedef enum logic [3:0] {
        ACT_NONE,
        ACT_ALLOC_NEW,
        ACT_POP_REQ,
        ACT_POP_DONE,
        ACT_FREE,
        ACT_MARK,
        ACT_ERROR,
        ACT_SCAN_INIT,
        ACT_SCAN_STEP,
        ACT_SCAN_END
    } t_act;

    typedef struct packed {
        t_act       act;
        logic [1:0] err;
        logic       sweep;
    } t_cmd;

    typedef struct packed {
        logic       stack_empty;
        logic       ids_full;
        logic [1:0] chk_err;
        logic       scan_done;
    } t_status;

endpackage
`default_nettype wire

>>> rtl/idalloc_ctrl.sv
`default_nettype none
module idalloc_ctrl (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_start,
    input  wire logic [2:0]           i_operation,
    input  wire idalloc_pkg::t_status i_status,
    output idalloc_pkg::t_cmd         o_cmd,
    output logic                      o_busy
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_POP  = 3'b010,
        S_SCAN = 3'b100
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != S_IDLE);

    always_comb begin
        n_state     = r_state;
        o_cmd.act   = idalloc_pkg::ACT_NONE;
        o_cmd.err   = idalloc_pkg::ERR_NONE;
        o_cmd.sweep = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    case (i_operation)
                        idalloc_pkg::OP_ALLOC: begin
                            if (!i_status.stack_empty) begin
                                o_cmd.act = idalloc_pkg::ACT_POP_REQ;
                                n_state   = S_POP;
                            end else if (!i_status.ids_full) begin
                                o_cmd.act = idalloc_pkg::ACT_ALLOC_NEW;
                            end else begin
                                o_cmd.act = idalloc_pkg::ACT_ERROR;
                                o_cmd.err = idalloc_pkg::ERR_FULL;
                            end
                        end
                        idalloc_pkg::OP_FREE, idalloc_pkg::OP_MARK: begin
                            if (i_status.chk_err != idalloc_pkg::ERR_NONE) begin
                                o_cmd.act = idalloc_pkg::ACT_ERROR;
                                o_cmd.err = i_status.chk_err;
                            end else if (i_operation == idalloc_pkg::OP_FREE) begin
                                o_cmd.act = idalloc_pkg::ACT_FREE;
                            end else begin
                                o_cmd.act = idalloc_pkg::ACT_MARK;
                            end
                        end
                        idalloc_pkg::OP_SWEEP, idalloc_pkg::OP_LIST: begin
                            o_cmd.act   = idalloc_pkg::ACT_SCAN_INIT;
                            o_cmd.sweep = (i_operation == idalloc_pkg::OP_SWEEP);
                            n_state     = S_SCAN;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_POP: begin
                o_cmd.act = idalloc_pkg::ACT_POP_DONE;
                n_state   = S_IDLE;
            end
            S_SCAN: begin
                if (i_status.scan_done) begin
                    o_cmd.act = idalloc_pkg::ACT_SCAN_END;
                    n_state   = S_IDLE;
                end else begin
                    o_cmd.act = idalloc_pkg::ACT_SCAN_STEP;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

>>> rtl/idalloc_dp.sv
`default_nettype none
module idalloc_dp #(
    parameter int CAPACITY = 64
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic [idalloc_pkg::ID_W-1:0]        i_target_id,
    input  wire idalloc_pkg::t_cmd                   i_cmd,
    output idalloc_pkg::t_status                     o_status,
    output logic                                     o_strobe,
    output logic [2:0]                               o_kind,
    output logic [idalloc_pkg::ID_W-1:0]             o_result_id,
    output logic                                     o_reused,
    output logic [1:0]                               o_error_code,
    output logic                                     o_last,
    output logic [idalloc_pkg::CNT_W-1:0]            o_next_unassigned
);

    localparam int IW = $clog2(CAPACITY);
    localparam logic [idalloc_pkg::CNT_W-1:0] CAP_C = idalloc_pkg::CNT_W'(CAPACITY);

    logic [CAPACITY-1:0]                r_alive, n_alive;
    logic [CAPACITY-1:0]                r_mark, n_mark;
    logic [idalloc_pkg::CNT_W-1:0]      r_stack_cnt, n_stack_cnt;
    logic [idalloc_pkg::CNT_W-1:0]      r_next_id, n_next_id;
    logic [idalloc_pkg::CNT_W-1:0]      r_scan, n_scan;
    logic [idalloc_pkg::ID_W-1:0]       r_pend, n_pend;
    logic                               r_pend_v, n_pend_v;
    logic                               r_sweep, n_sweep;
    logic                               r_strobe, n_strobe;
    logic [2:0]                         r_kind, n_kind;
    logic [idalloc_pkg::ID_W-1:0]       r_id, n_id;
    logic                               r_reused, n_reused;
    logic [1:0]                         r_err, n_err;
    logic                               r_last, n_last;

    logic [idalloc_pkg::ID_W-1:0]       r_stack [CAPACITY];
    logic [idalloc_pkg::ID_W-1:0]       r_rd;
    logic [idalloc_pkg::CNT_W-1:0]      pop_addr;
    logic                               push_en;
    logic [idalloc_pkg::ID_W-1:0]       push_id;
    logic                               hit;
    logic [2:0]                         scan_kind;

    assign pop_addr  = r_stack_cnt - idalloc_pkg::CNT_W'(1);
    assign hit       = r_alive[r_scan[IW-1:0]] && (!r_sweep || r_mark[r_scan[IW-1:0]]);
    assign scan_kind = r_sweep ? idalloc_pkg::KIND_KILLED : idalloc_pkg::KIND_LISTED;

    // Range check first so that the alive lookup only sees legal indexes.
    always_comb begin
        o_status.stack_empty = (r_stack_cnt == '0);
        o_status.ids_full    = (r_next_id >= CAP_C);
        o_status.scan_done   = (r_scan >= r_next_id);
        if ((i_target_id == '0) || ({1'b0, i_target_id} >= r_next_id)) begin
            o_status.chk_err = idalloc_pkg::ERR_RANGE;
        end else if (!r_alive[i_target_id[IW-1:0]]) begin
            o_status.chk_err = idalloc_pkg::ERR_DEAD;
        end else begin
            o_status.chk_err = idalloc_pkg::ERR_NONE;
        end
    end

    always_comb begin
        n_alive     = r_alive;
        n_mark      = r_mark;
        n_stack_cnt = r_stack_cnt;
        n_next_id   = r_next_id;
        n_scan      = r_scan;
        n_pend      = r_pend;
        n_pend_v    = r_pend_v;
        n_sweep     = r_sweep;
        n_strobe    = 1'b0;
        n_kind      = r_kind;
        n_id        = r_id;
        n_reused    = 1'b0;
        n_err       = idalloc_pkg::ERR_NONE;
        n_last      = 1'b1;
        push_en     = 1'b0;
        push_id     = i_target_id;
        case (i_cmd.act)
            idalloc_pkg::ACT_ALLOC_NEW: begin
                n_alive[r_next_id[IW-1:0]] = 1'b1;
                n_mark[r_next_id[IW-1:0]]  = 1'b0;
                n_next_id = r_next_id + idalloc_pkg::CNT_W'(1);
                n_strobe  = 1'b1;
                n_kind    = idalloc_pkg::KIND_ALLOC;
                n_id      = r_next_id[idalloc_pkg::ID_W-1:0];
            end
            idalloc_pkg::ACT_POP_REQ: begin
                n_stack_cnt = pop_addr;
            end
            idalloc_pkg::ACT_POP_DONE: begin
                n_alive[r_rd[IW-1:0]] = 1'b1;
                n_mark[r_rd[IW-1:0]]  = 1'b0;
                n_strobe = 1'b1;
                n_kind   = idalloc_pkg::KIND_ALLOC;
                n_id     = r_rd;
                n_reused = 1'b1;
            end
            idalloc_pkg::ACT_FREE: begin
                n_alive[i_target_id[IW-1:0]] = 1'b0;
                n_mark[i_target_id[IW-1:0]]  = 1'b0;
                push_en  = 1'b1;
                n_strobe = 1'b1;
                n_kind   = idalloc_pkg::KIND_KILLED;
                n_id     = i_target_id;
            end
            idalloc_pkg::ACT_MARK: begin
                n_mark[i_target_id[IW-1:0]] = 1'b1;
            end
            idalloc_pkg::ACT_ERROR: begin
                n_strobe = 1'b1;
                n_kind   = idalloc_pkg::KIND_ERROR;
                n_id     = '0;
                n_err    = i_cmd.err;
            end
            idalloc_pkg::ACT_SCAN_INIT: begin
                n_scan   = idalloc_pkg::CNT_W'(1);
                n_pend_v = 1'b0;
                n_sweep  = i_cmd.sweep;
            end
            idalloc_pkg::ACT_SCAN_STEP: begin
                n_scan = r_scan + idalloc_pkg::CNT_W'(1);
                if (hit) begin
                    // The previous hit is now known not to be the final one.
                    n_strobe = r_pend_v;
                    n_kind   = scan_kind;
                    n_id     = r_pend;
                    n_last   = 1'b0;
                    n_pend   = r_scan[idalloc_pkg::ID_W-1:0];
                    n_pend_v = 1'b1;
                    if (r_sweep) begin
                        n_alive[r_scan[IW-1:0]] = 1'b0;
                        n_mark[r_scan[IW-1:0]]  = 1'b0;
                        push_en = 1'b1;
                        push_id = r_scan[idalloc_pkg::ID_W-1:0];
                    end
                end
            end
            idalloc_pkg::ACT_SCAN_END: begin
                n_strobe = 1'b1;
                n_kind   = r_pend_v ? scan_kind : idalloc_pkg::KIND_NONE;
                n_id     = r_pend_v ? r_pend : '0;
            end
            default: begin
            end
        endcase
        if (push_en && (r_stack_cnt < CAP_C)) begin
            n_stack_cnt = r_stack_cnt + idalloc_pkg::CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alive     <= '0;
            r_mark      <= '0;
            r_stack_cnt <= '0;
            r_next_id   <= idalloc_pkg::CNT_W'(1);
            r_pend_v    <= 1'b0;
            r_strobe    <= 1'b0;
        end else begin
            r_alive     <= n_alive;
            r_mark      <= n_mark;
            r_stack_cnt <= n_stack_cnt;
            r_next_id   <= n_next_id;
            r_pend_v    <= n_pend_v;
            r_strobe    <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_scan   <= n_scan;
        r_pend   <= n_pend;
        r_sweep  <= n_sweep;
        r_kind   <= n_kind;
        r_id     <= n_id;
        r_reused <= n_reused;
        r_err    <= n_err;
        r_last   <= n_last;
    end

    // Free stack: one write port for pushes, one registered read for pops.
    always_ff @(posedge i_clk) begin
        if (push_en && (r_stack_cnt < CAP_C)) begin
            r_stack[r_stack_cnt[IW-1:0]] <= push_id;
        end
        r_rd <= r_stack[pop_addr[IW-1:0]];
    end

    assign o_strobe          = r_strobe;
    assign o_kind            = r_kind;
    assign o_result_id       = r_id;
    assign o_reused          = r_reused;
    assign o_error_code      = r_err;
    assign o_last            = r_last;
    assign o_next_unassigned = r_next_id;

endmodule
`default_nettype wire

>>> rtl/id_allocator_free_stack_unit.sv
`default_nettype none
// Channel | Ports                                        | Dir | Handshake
// request | i_operation, i_target_id                     | in  | i_start && !o_busy
// result  | o_kind through o_next_unassigned, six ports  | out | o_strobe, one cycle each
//
// A fresh allocation, a free and any error leave o_busy low and give their one result in
// the cycle after the request is taken; a good mark leaves o_busy low and gives none.
// A reused id holds o_busy in S_POP for the registered free stack read, then its result
// is registered. Sweep and list hold o_busy while the scan visits each id from 1 and
// then closes; a hit waits as pending, so the final result comes out as o_busy drops.
// Reset is synchronous, active low; the free stack needs none. The receiver cannot stall.
module id_allocator_free_stack_unit #(
    parameter int CAPACITY = 64
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_start,
    output logic                              o_busy,
    input  wire logic [2:0]                   i_operation,
    input  wire logic [idalloc_pkg::ID_W-1:0] i_target_id,
    output logic                              o_strobe,
    output logic [2:0]                        o_kind,
    output logic [idalloc_pkg::ID_W-1:0]      o_result_id,
    output logic                              o_reused,
    output logic [1:0]                        o_error_code,
    output logic                              o_last,
    output logic [idalloc_pkg::CNT_W-1:0]     o_next_unassigned
);

    // Commands flow from the controller to the datapath, status flows back.
    idalloc_pkg::t_cmd    cmd;
    idalloc_pkg::t_status status;

    idalloc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_start),
        .i_operation (i_operation),
        .i_status    (status),
        .o_cmd       (cmd),
        .o_busy      (o_busy)
    );

    // The datapath owns the alive and mark bits, the free stack memory, the
    // counters, the scan pointer with its one pending hit, and the result
    // registers. A scan hit is held back until the next hit or the scan end so
    // that the final one can carry the last flag.
    idalloc_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_target_id       (i_target_id),
        .i_cmd             (cmd),
        .o_status          (status),
        .o_strobe          (o_strobe),
        .o_kind            (o_kind),
        .o_result_id       (o_result_id),
        .o_reused          (o_reused),
        .o_error_code      (o_error_code),
        .o_last            (o_last),
        .o_next_unassigned (o_next_unassigned)
    );

`ifndef SYNTHESIS
    // An error result always carries a nonzero code and no id.
    a_error_coded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && (o_kind == idalloc_pkg::KIND_ERROR)) |->
        ((o_error_code != idalloc_pkg::ERR_NONE) && (o_result_id == '0)))
        else $error("error result without code");

    // A result that is not the last one only comes out during a scan.
    a_not_last_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_last) |-> o_busy)
        else $error("non-final result outside a scan");

    // Only scan results may leave the last flag clear.
    a_single_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && (o_kind != idalloc_pkg::KIND_KILLED)
         && (o_kind != idalloc_pkg::KIND_LISTED)) |-> o_last)
        else $error("single result without last flag");

    // The bump counter stays within 1 .. CAPACITY.
    a_next_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> ((o_next_unassigned != '0)
        && (o_next_unassigned <= idalloc_pkg::CNT_W'(CAPACITY))))
        else $error("next id out of range");
`endif

endmodule
`default_nettype wire

>>> sim/id_allocator_free_stack_unit_tb.sv
`timescale 1ns / 100ps

module id_allocator_free_stack_unit_tb;

    localparam int ID_W  = idalloc_pkg::ID_W;
    localparam int CNT_W = idalloc_pkg::CNT_W;

    // A cycle stretch with no request taken and no result seen beyond this
    // count means the block hung. The slowest legal stretch is a full scan
    // of 63 ids plus the longest sender gap, so this leaves a wide margin.
    localparam int STALL_LIMIT = 2000;
    // Cycles allowed for stray results after the last expected one.
    localparam int TAIL_CYCLES = 80;
    localparam int MAX_REPORTS = 10;
    localparam int POOL_SIZE   = 64;

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               i_start;
    logic               o_busy;
    logic [2:0]         i_operation;
    logic [ID_W-1:0]    i_target_id;
    logic               o_strobe;
    logic [2:0]         o_kind;
    logic [ID_W-1:0]    o_result_id;
    logic               o_reused;
    logic [1:0]         o_error_code;
    logic               o_last;
    logic [CNT_W-1:0]   o_next_unassigned;

    id_allocator_free_stack_unit #(
        .CAPACITY(POOL_SIZE)
    ) dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_start          (i_start),
        .o_busy           (o_busy),
        .i_operation      (i_operation),
        .i_target_id      (i_target_id),
        .o_strobe         (o_strobe),
        .o_kind           (o_kind),
        .o_result_id      (o_result_id),
        .o_reused         (o_reused),
        .o_error_code     (o_error_code),
        .o_last           (o_last),
        .o_next_unassigned(o_next_unassigned)
    );

    // Free-running clock, 10 ns period.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // One result as the block should report it.
    typedef struct {
        logic [2:0]       kind;
        logic [ID_W-1:0]  id;
        logic             reused;
        logic [1:0]       err;
        logic             last;
        logic [CNT_W-1:0] next_free;
    } t_id_event;

    // Results still owed by the block, oldest first.
    t_id_event owed_events[$];

    // Shadow copy of the allocator state, updated as each request is taken.
    logic [POOL_SIZE-1:0] shadow_alive;
    logic [POOL_SIZE-1:0] shadow_marked;
    logic [ID_W-1:0]      shadow_stack [POOL_SIZE];
    logic [CNT_W-1:0]     shadow_depth;
    logic [CNT_W-1:0]     shadow_next;

    int  mismatch_count;
    int  idle_cycles;
    // When set, the sender never inserts gaps between requests.
    bit  steady_drive;

    // -----------------------------------------------------------------
    // Shadow allocator
    // -----------------------------------------------------------------

    task automatic owe_event(input logic [2:0] kind, input logic [ID_W-1:0] id,
                             input logic reused, input logic [1:0] err,
                             input logic last);
        t_id_event ev;
        ev.kind      = kind;
        ev.id        = id;
        ev.reused    = reused;
        ev.err       = err;
        ev.last      = last;
        ev.next_free = shadow_next;
        owed_events.insert(owed_events.size(), ev);
    endtask

    // Returns the error a free or mark of this id would raise, or none.
    function automatic logic [1:0] liveness_error(input logic [ID_W-1:0] id);
        if (id == '0 || CNT_W'(id) >= shadow_next) begin
            return idalloc_pkg::ERR_RANGE;
        end
        if (!shadow_alive[id]) begin
            return idalloc_pkg::ERR_DEAD;
        end
        return idalloc_pkg::ERR_NONE;
    endfunction

    // Killing an id also clears its mark, so a revived id starts clean.
    task automatic retire_id(input logic [ID_W-1:0] id);
        shadow_alive[id]  = 1'b0;
        shadow_marked[id] = 1'b0;
        if (shadow_depth < CNT_W'(POOL_SIZE)) begin
            shadow_stack[shadow_depth[ID_W-1:0]] = id;
            shadow_depth = shadow_depth + CNT_W'(1);
        end
    endtask

    // Applies one accepted request to the shadow state and queues the
    // results it must produce.
    task automatic apply_request(input logic [2:0] op, input logic [ID_W-1:0] tid);
        logic [1:0]      err;
        logic [ID_W-1:0] id;
        logic            reused;
        int              hits;
        int              emitted;
        case (op)
            idalloc_pkg::OP_ALLOC: begin
                if (shadow_depth != '0) begin
                    shadow_depth = shadow_depth - CNT_W'(1);
                    id = shadow_stack[shadow_depth[ID_W-1:0]];
                    reused = 1'b1;
                end else if (shadow_next < CNT_W'(POOL_SIZE)) begin
                    id = shadow_next[ID_W-1:0];
                    shadow_next = shadow_next + CNT_W'(1);
                    reused = 1'b0;
                end else begin
                    // Pool exhausted: a single error, nothing changes.
                    owe_event(idalloc_pkg::KIND_ERROR, '0, 1'b0,
                              idalloc_pkg::ERR_FULL, 1'b1);
                    return;
                end
                shadow_alive[id]  = 1'b1;
                shadow_marked[id] = 1'b0;
                owe_event(idalloc_pkg::KIND_ALLOC, id, reused, idalloc_pkg::ERR_NONE, 1'b1);
            end
            idalloc_pkg::OP_FREE: begin
                err = liveness_error(tid);
                if (err != idalloc_pkg::ERR_NONE) begin
                    owe_event(idalloc_pkg::KIND_ERROR, '0, 1'b0, err, 1'b1);
                end else begin
                    retire_id(tid);
                    owe_event(idalloc_pkg::KIND_KILLED, tid, 1'b0,
                              idalloc_pkg::ERR_NONE, 1'b1);
                end
            end
            idalloc_pkg::OP_MARK: begin
                err = liveness_error(tid);
                if (err != idalloc_pkg::ERR_NONE) begin
                    owe_event(idalloc_pkg::KIND_ERROR, '0, 1'b0, err, 1'b1);
                end else begin
                    // A good mark produces no result at all.
                    shadow_marked[tid] = 1'b1;
                end
            end
            idalloc_pkg::OP_SWEEP, idalloc_pkg::OP_LIST: begin
                // Count the hits first so the final one can carry last.
                hits = 0;
                for (int i = 1; i < POOL_SIZE && CNT_W'(i) < shadow_next; i++) begin
                    if (shadow_alive[i] &&
                        (op == idalloc_pkg::OP_LIST || shadow_marked[i])) begin
                        hits++;
                    end
                end
                if (hits == 0) begin
                    owe_event(idalloc_pkg::KIND_NONE, '0, 1'b0, idalloc_pkg::ERR_NONE, 1'b1);
                end else begin
                    emitted = 0;
                    for (int i = 1; i < POOL_SIZE && CNT_W'(i) < shadow_next; i++) begin
                        if (shadow_alive[i] &&
                            (op == idalloc_pkg::OP_LIST || shadow_marked[i])) begin
                            emitted++;
                            if (op == idalloc_pkg::OP_SWEEP) begin
                                retire_id(ID_W'(i));
                                owe_event(idalloc_pkg::KIND_KILLED, ID_W'(i), 1'b0,
                                          idalloc_pkg::ERR_NONE, emitted == hits);
                            end else begin
                                owe_event(idalloc_pkg::KIND_LISTED, ID_W'(i), 1'b0,
                                          idalloc_pkg::ERR_NONE, emitted == hits);
                            end
                        end
                    end
                end
            end
            default: begin
                // Codes above list are ignored by the block.
            end
        endcase
    endtask

    // Picks a live id at random, or any id when none is live.
    function automatic logic [ID_W-1:0] pick_live_id();
        logic [ID_W-1:0] live_ids [POOL_SIZE];
        int              n_live;
        n_live = 0;
        for (int i = 1; i < POOL_SIZE; i++) begin
            if (shadow_alive[i]) begin
                live_ids[n_live] = ID_W'(i);
                n_live++;
            end
        end
        if (n_live == 0) begin
            return ID_W'($urandom_range(POOL_SIZE - 1));
        end
        return live_ids[$urandom_range(n_live - 1)];
    endfunction

    // -----------------------------------------------------------------
    // Request driver
    // -----------------------------------------------------------------

    // Presents one request, holds it until the block takes it, updates the
    // shadow state, then maybe idles the request side for a while. This is
    // entered right after a rising edge, so the assignments below are the
    // only ones made to these inputs in this time step.
    task automatic send_request(input logic [2:0] op, input logic [ID_W-1:0] tid);
        int gap;
        i_start     <= 1'b1;
        i_operation <= op;
        i_target_id <= tid;
        @(posedge i_clk);
        while (o_busy) begin
            @(posedge i_clk);
        end
        apply_request(op, tid);
        if (!steady_drive && $urandom_range(99) < 17) begin
            gap = ($urandom_range(9) == 0) ? $urandom_range(10, 70) : $urandom_range(1, 4);
            i_start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // -----------------------------------------------------------------
    // Result checker
    // -----------------------------------------------------------------

    // Outputs are sampled on the rising edge before the block updates them,
    // so each strobe is compared against the oldest result still owed.
    always @(posedge i_clk) begin
        t_id_event want;
        if (i_rst_n && o_strobe) begin
            if (owed_events.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS) begin
                    $display("%0t: unexpected result kind=%0d id=%0d reused=%0b err=%0d",
                             $time, o_kind, o_result_id, o_reused, o_error_code);
                    $display("%0t:          last=%0b next=%0d",
                             $time, o_last, o_next_unassigned);
                end
            end else begin
                want = owed_events.pop_front();
                if (o_kind !== want.kind || o_result_id !== want.id ||
                    o_reused !== want.reused || o_error_code !== want.err ||
                    o_last !== want.last || o_next_unassigned !== want.next_free) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS) begin
                        $display({"%0t: mismatch expected kind=%0d id=%0d reused=%0b",
                                  " err=%0d last=%0b next=%0d"},
                                 $time, want.kind, want.id, want.reused, want.err,
                                 want.last, want.next_free);
                        $display({"%0t:          actual   kind=%0d id=%0d reused=%0b",
                                  " err=%0d last=%0b next=%0d"},
                                 $time, o_kind, o_result_id, o_reused, o_error_code,
                                 o_last, o_next_unassigned);
                    end
                end
            end
        end
    end

    // Watchdog: any taken request or any result counts as progress.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_start && !o_busy) || o_strobe) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // -----------------------------------------------------------------
    // Tests
    // -----------------------------------------------------------------

    // Sweep and list on a fresh pool must each give a single none result.
    task automatic test_empty_scans();
        send_request(idalloc_pkg::OP_SWEEP, 6'd0);
        send_request(idalloc_pkg::OP_LIST, 6'd63);
    endtask

    // Id zero and ids at or past the bump counter are out of range.
    task automatic test_range_errors();
        send_request(idalloc_pkg::OP_FREE, 6'd0);
        send_request(idalloc_pkg::OP_FREE, 6'd5);
        send_request(idalloc_pkg::OP_MARK, 6'd0);
        send_request(idalloc_pkg::OP_MARK, 6'd63);
    endtask

    // Fresh allocations, a free, a double free and a mark of a dead id,
    // then a reuse from the free stack and a list.
    task automatic test_alloc_free_reuse();
        send_request(idalloc_pkg::OP_ALLOC, 6'd0);
        send_request(idalloc_pkg::OP_ALLOC, 6'd42);
        send_request(idalloc_pkg::OP_ALLOC, 6'd0);
        send_request(idalloc_pkg::OP_FREE, 6'd2);
        send_request(idalloc_pkg::OP_FREE, 6'd2);
        send_request(idalloc_pkg::OP_MARK, 6'd2);
        send_request(idalloc_pkg::OP_ALLOC, 6'd0);
        send_request(idalloc_pkg::OP_LIST, 6'd0);
    endtask

    // Marking twice is harmless, a sweep kills marked ids in order, and
    // ids revived from the stack come back unmarked.
    task automatic test_mark_sweep();
        send_request(idalloc_pkg::OP_MARK, 6'd1);
        send_request(idalloc_pkg::OP_MARK, 6'd1);
        send_request(idalloc_pkg::OP_MARK, 6'd3);
        send_request(idalloc_pkg::OP_SWEEP, 6'd0);
        send_request(idalloc_pkg::OP_ALLOC, 6'd0);
        send_request(idalloc_pkg::OP_ALLOC, 6'd0);
        send_request(idalloc_pkg::OP_SWEEP, 6'd0);
        send_request(idalloc_pkg::OP_LIST, 6'd0);
    endtask

    // Undefined operation codes must produce nothing.
    task automatic test_ignored_codes();
        for (int k = 1; k <= 3; k++) begin
            send_request(idalloc_pkg::OP_LIST + 3'(k), ID_W'($urandom_range(POOL_SIZE - 1)));
        end
    endtask

    // Allocates until the pool is exhausted, hits the full error, lists the
    // whole pool, sweeps a random handful of marked ids, reallocates, frees 63.
    task automatic test_fill_pool();
        while (shadow_depth != '0 || shadow_next < CNT_W'(POOL_SIZE)) begin
            send_request(idalloc_pkg::OP_ALLOC, ID_W'($urandom_range(POOL_SIZE - 1)));
        end
        send_request(idalloc_pkg::OP_ALLOC, 6'd0);
        send_request(idalloc_pkg::OP_LIST, 6'd0);
        send_request(idalloc_pkg::OP_MARK, 6'd63);
        repeat (12) send_request(idalloc_pkg::OP_MARK, pick_live_id());
        send_request(idalloc_pkg::OP_SWEEP, 6'd0);
        send_request(idalloc_pkg::OP_ALLOC, 6'd0);
        send_request(idalloc_pkg::OP_FREE, 6'd63);
    endtask

    // Mostly well-formed traffic on live ids, with some stray targets.
    // The first stretch is driven back to back with no gaps.
    task automatic test_random_mix(input int count);
        int              roll;
        logic [2:0]      op;
        logic [ID_W-1:0] tid;
        for (int n = 0; n < count; n++) begin
            steady_drive = (n < count / 4);
            roll = $urandom_range(99);
            if (roll < 35) begin
                op = idalloc_pkg::OP_ALLOC;
            end else if (roll < 57) begin
                op = idalloc_pkg::OP_FREE;
            end else if (roll < 80) begin
                op = idalloc_pkg::OP_MARK;
            end else if (roll < 88) begin
                op = idalloc_pkg::OP_SWEEP;
            end else if (roll < 95) begin
                op = idalloc_pkg::OP_LIST;
            end else begin
                op = idalloc_pkg::OP_LIST + 3'($urandom_range(1, 3));
            end
            if ($urandom_range(99) < 75) begin
                tid = pick_live_id();
            end else begin
                tid = ID_W'($urandom_range(POOL_SIZE - 1));
            end
            send_request(op, tid);
        end
        steady_drive = 1'b0;
    endtask

    // Stops driving, waits for every owed result, then for a tail in which
    // any stray result would show up, and reports.
    task automatic finish_run();
        i_start <= 1'b0;
        while (owed_events.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    endtask

    initial begin
        i_rst_n     <= 1'b0;
        i_start     <= 1'b0;
        i_operation <= idalloc_pkg::OP_ALLOC;
        i_target_id <= '0;
        mismatch_count = 0;
        idle_cycles    = 0;
        steady_drive   = 1'b0;
        shadow_alive   = '0;
        shadow_marked  = '0;
        shadow_depth   = '0;
        shadow_next    = CNT_W'(1);
        for (int i = 0; i < POOL_SIZE; i++) begin
            shadow_stack[i] = '0;
        end
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_scans();
        test_range_errors();
        test_alloc_free_reuse();
        test_mark_sweep();
        test_ignored_codes();
        test_fill_pool();
        test_random_mix(150);
        finish_run();
    end

endmodule
